>>> rtl/nlms_pkg.sv
package nlms_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_ACC,
      ST_ERR,
      ST_UPD_MUL,
      ST_UPD_DIV,
      ST_UPD_WR,
      ST_OUT
   } nlms_state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;      // capture request, shift history
      logic acc_clr;
      logic acc_step;  // accumulate one tap
      logic err_calc;
      logic upd_mul;   // form numerator for current tap
      logic div_start;
      logic upd_wr;    // write updated weight
      logic idx_clr;
      logic idx_inc;
   } nlms_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic div_done;
   } nlms_sts_type;

   localparam int SAMPLE_W = 16;
   localparam int WEIGHT_W = 32;
   localparam int MU_W     = 16;
   localparam int FRAC_W   = 27;
   localparam int SHIFT_W  = 12;
   localparam int NUM_W    = 60;   // 16u*16s*16s<<12 fits in 60 signed bits
   localparam int ACC_W    = 64;

endpackage

>>> rtl/nlms_div.sv
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
module nlms_div
   import nlms_pkg::*;
#(
   parameter int NW = 60,
   parameter int DW = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] num,
   input  logic        [DW-1:0] den,
   output logic                 done,
   output logic signed [NW-1:0] quot
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff;
   logic          neg_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW:0]   trial;

   always_comb begin
      trial   = {r_ff[DW-1:0], q_ff[NW-1]} - {1'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         if (!trial[DW]) begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DW-1:0], q_ff[NW-1]};
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(NW);
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      if (start) begin
         q_ff   <= num[NW-1] ? NW'(-num) : num;
         r_ff   <= '0;
         d_ff   <= den;
         neg_ff <= num[NW-1];
      end else begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign done = !busy_ff && !start;
   assign quot = neg_ff ? -$signed(q_ff) : $signed(q_ff);
endmodule

>>> rtl/nlms_ctrl.sv
module nlms_ctrl
   import nlms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  nlms_sts_type sts,
   output nlms_cmd_type cmd
);
   nlms_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_SHIFT;
         ST_SHIFT:   state_in = ST_ACC;
         ST_ACC:     if (sts.idx_last) state_in = ST_ERR;
         ST_ERR:     state_in = ST_UPD_MUL;
         ST_UPD_MUL: state_in = ST_UPD_DIV;
         ST_UPD_DIV: if (sts.div_done) state_in = ST_UPD_WR;
         ST_UPD_WR:  state_in = sts.idx_last ? ST_OUT : ST_UPD_MUL;
         ST_OUT:     if (rsp_ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SHIFT: begin
            cmd.acc_clr = 1'b1;
            cmd.idx_clr = 1'b1;
         end
         ST_ACC: begin
            cmd.acc_step = 1'b1;
            cmd.idx_inc  = 1'b1;
         end
         ST_ERR: begin
            cmd.err_calc = 1'b1;
            cmd.idx_clr  = 1'b1;
         end
         ST_UPD_MUL: begin
            cmd.upd_mul   = 1'b1;
            cmd.div_start = 1'b1;
         end
         ST_UPD_DIV: ;
         ST_UPD_WR: begin
            cmd.upd_wr  = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end
endmodule

>>> rtl/nlms_dp.sv
module nlms_dp
   import nlms_pkg::*;
#(
   parameter int TAPS     = 8,
   parameter int CHANNELS = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [SAMPLE_W-1:0] ref_a,
   input  logic signed [SAMPLE_W-1:0] ref_b,
   input  logic signed [SAMPLE_W-1:0] ref_c,
   input  logic signed [SAMPLE_W-1:0] desired,
   input  logic        [MU_W-1:0]     mu,
   input  nlms_cmd_type               cmd,
   output nlms_sts_type               sts,
   output logic signed [SAMPLE_W-1:0] err_out
);
   localparam int N  = TAPS * CHANNELS;
   localparam int IW = (N > 1) ? $clog2(N) : 1;
   localparam int EW = 2 * SAMPLE_W + $clog2(N + 1);

   // history as taps of a shift line; weights as a memory with valid bits
   logic signed [SAMPLE_W-1:0] hist_ff [N];
   logic signed [WEIGHT_W-1:0] wmem [N];
   logic [N-1:0]               wval_ff;
   logic [IW-1:0]              idx_ff;
   logic signed [SAMPLE_W-1:0] des_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic [EW-1:0]              en_ff;
   logic signed [SAMPLE_W-1:0] e_ff;
   logic signed [SAMPLE_W-1:0] e_sat;
   logic signed [NUM_W-1:0]    num_ff;
   logic signed [SAMPLE_W-1:0] x;
   logic signed [WEIGHT_W-1:0] w;
   logic signed [ACC_W-1:0]    y, diff;
   logic signed [NUM_W-1:0]    quot;
   logic signed [NUM_W:0]      wsum;
   logic                       div_done;
   logic signed [2*SAMPLE_W-1:0] prod_ff;
   logic signed [WEIGHT_W+SAMPLE_W-1:0] wx;
   logic signed [2*SAMPLE_W-1:0]        xsq;
   logic signed [3*SAMPLE_W-1:0]        px;

   assign x = hist_ff[idx_ff];
   assign w = wval_ff[idx_ff] ? wmem[idx_ff] : '0;

   // full-width products
   assign wx  = w * x;
   assign xsq = x * x;
   assign px  = prod_ff * x;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) hist_ff[i] <= '0;
         wval_ff <= '0;
      end else begin
         if (cmd.load) begin
            for (int c = 0; c < CHANNELS; c++) begin
               for (int t = TAPS - 1; t > 0; t--)
                  hist_ff[c*TAPS+t] <= hist_ff[c*TAPS+t-1];
            end
            hist_ff[0] <= ref_a;
            if (CHANNELS > 1) hist_ff[(CHANNELS > 1 ? 1 : 0)*TAPS] <= ref_b;
            if (CHANNELS > 2) hist_ff[(CHANNELS > 2 ? 2 : 0)*TAPS] <= ref_c;
         end
         if (cmd.upd_wr) wval_ff[idx_ff] <= 1'b1;
      end
   end

   always_comb begin
      wsum = NUM_W'(w) + quot;
      if (wsum > (NUM_W+1)'(2147483647)) wsum = (NUM_W+1)'(2147483647);
      else if (wsum < -(NUM_W+1)'(64'sd2147483648)) wsum = -(NUM_W+1)'(64'sd2147483648);
   end

   always_ff @(posedge clock) begin
      if (cmd.upd_wr) wmem[idx_ff] <= wsum[WEIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else if (cmd.idx_clr) idx_ff <= '0;
      else if (cmd.idx_inc) idx_ff <= (idx_ff == IW'(N - 1)) ? '0 : idx_ff + 1'b1;
   end
   assign sts.idx_last = (idx_ff == IW'(N - 1));
   assign sts.div_done = div_done;

   // ST_ACC: one 32x16 product per tap, energy square in parallel
   always_ff @(posedge clock) begin
      if (cmd.load) des_ff <= desired;
      if (cmd.acc_clr) begin
         acc_ff <= '0;
         en_ff  <= '0;
      end else if (cmd.acc_step) begin
         acc_ff <= acc_ff + ACC_W'(wx);
         en_ff  <= en_ff + EW'($unsigned(xsq));
      end
   end

   assign y    = acc_ff >>> FRAC_W;
   assign diff = ACC_W'(des_ff) - y;

   always_comb begin
      if (diff > 64'sd32767)       e_sat = 16'sh7fff;
      else if (diff < -64'sd32768) e_sat = 16'sh8000;
      else                         e_sat = diff[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.err_calc) begin
         e_ff    <= e_sat;
         prod_ff <= $signed({1'b0, mu}) * e_sat;
      end
      if (cmd.upd_mul) num_ff <= NUM_W'(px) <<< SHIFT_W;
   end

   logic [EW-1:0] den;
   assign den = (en_ff == '0) ? EW'(1) : en_ff;

   logic div_go_ff;
   always_ff @(posedge clock) begin
      if (reset) div_go_ff <= 1'b0;
      else       div_go_ff <= cmd.div_start;
   end

   nlms_div #(.NW(NUM_W), .DW(EW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (num_ff),
      .den   (den),
      .done  (div_done),
      .quot  (quot)
   );

   assign err_out = e_ff;
endmodule

>>> rtl/nlms_three_input_filter_core.sv
// Three-channel NLMS adaptive FIR (TAPS taps per channel, Q4.27 weights).
// One request at a time. For each tap, the update pass runs a multiply step,
// the divider (one quotient bit per cycle between its start and done) and a
// weight write. The error result is held on rsp_ until taken; the next
// request is accepted after that. Write mu over csr_ only while no request
// is in flight.
module nlms_three_input_filter_core
   import nlms_pkg::*;
#(
   parameter int TAPS     = 8,
   parameter int CHANNELS = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_ref_sample_a,
   input  logic signed [SAMPLE_W-1:0] req_ref_sample_b,
   input  logic signed [SAMPLE_W-1:0] req_ref_sample_c,
   input  logic signed [SAMPLE_W-1:0] req_desired_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_error_sample,
   input  logic                       csr_write_enable,
   input  logic        [MU_W-1:0]     csr_write_data
);
   nlms_cmd_type cmd;
   nlms_sts_type sts;
   logic [MU_W-1:0] mu_ff;

   // step size register, Q1.15
   always_ff @(posedge clock) begin
      if (reset) mu_ff <= MU_W'(3277);
      else if (csr_write_enable) mu_ff <= csr_write_data;
   end

   nlms_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   nlms_dp #(.TAPS(TAPS), .CHANNELS(CHANNELS)) u_dp (
      .clock, .reset,
      .ref_a   (req_ref_sample_a),
      .ref_b   (req_ref_sample_b),
      .ref_c   (req_ref_sample_c),
      .desired (req_desired_sample),
      .mu      (mu_ff),
      .cmd, .sts,
      .err_out (rsp_error_sample)
   );

   // never ready for a request while a response is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready during response");
   // response stays until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   // an accepted request leaves idle
   a_acc: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("double accept");
endmodule

>>> verif/tb_nlms_three_input_filter_core.sv
module tb_nlms_three_input_filter_core;
   timeunit 1ns;
   timeprecision 1ps;
   import nlms_pkg::*;

   localparam int TAPS      = 8;
   localparam int CHANNELS  = 3;
   localparam int LINE_LEN  = TAPS * CHANNELS;
   localparam int RAND_REQS = 1430;
   // Per-request processing bound; the stall limit adds room for receiver stalls.
   localparam int REQ_CYCLES  = 4 + LINE_LEN + LINE_LEN * (NUM_W + 4);
   localparam int STALL_LIMIT = 20 * REQ_CYCLES + 2000;
   localparam logic [MU_W-1:0] MU_RESET = 16'd3277;

   // Scoreboard: own copy of the filter state, queue of expected errors.
   class nlms_error_scoreboard;
      logic [MU_W-1:0]             mu;
      logic signed [SAMPLE_W-1:0] history[LINE_LEN];
      logic signed [WEIGHT_W-1:0] weights[LINE_LEN];
      logic signed [SAMPLE_W-1:0] expected_errors[$];
      int                          mismatches;

      function void clear_state();
         mu = MU_RESET;
         foreach (history[k]) history[k] = '0;
         foreach (weights[k]) weights[k] = '0;
      endfunction

      // One filter step on an accepted request; queues the expected error.
      function void note_request(logic signed [SAMPLE_W-1:0] sa,
                                 logic signed [SAMPLE_W-1:0] sb,
                                 logic signed [SAMPLE_W-1:0] sc,
                                 logic signed [SAMPLE_W-1:0] desired);
         logic signed [SAMPLE_W-1:0] fresh[3];
         longint acc, energy, y, err, delta, w, x;
         fresh[0] = sa; fresh[1] = sb; fresh[2] = sc;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            for (int t = TAPS - 1; t > 0; t--)
               history[ch*TAPS + t] = history[ch*TAPS + t - 1];
            history[ch*TAPS] = fresh[ch];
         end
         acc = 0;
         energy = 0;
         for (int k = 0; k < LINE_LEN; k++) begin
            x = history[k];
            acc += longint'(weights[k]) * x;
            energy += x * x;
         end
         if (energy < 1) energy = 1;
         y = acc >>> FRAC_W;   // floor
         err = longint'(desired) - y;
         if (err > 32767) err = 32767;
         if (err < -32768) err = -32768;
         for (int k = 0; k < LINE_LEN; k++) begin
            x = history[k];
            delta = (longint'({1'b0, mu}) * err * x * (longint'(1) << SHIFT_W)) / energy;
            w = longint'(weights[k]) + delta;
            if (w > 64'sd2147483647) w = 64'sd2147483647;
            if (w < -64'sd2147483648) w = -64'sd2147483648;
            weights[k] = w[31:0];
         end
         expected_errors.push_back(err[15:0]);
      endfunction

      task check_response(logic signed [SAMPLE_W-1:0] got);
         logic signed [SAMPLE_W-1:0] want;
         if (expected_errors.size() == 0) begin
            report_mismatch($sformatf("unexpected response error=%0d", got));
            return;
         end
         want = expected_errors.pop_front();
         if (got !== want)
            report_mismatch($sformatf("error_sample got %0d want %0d", got, want));
      endtask

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         mismatches++;
      endtask
   endclass

   logic                       clock = 0;
   logic                       reset = 1;
   logic                       req_valid = 0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_ref_sample_a = '0;
   logic signed [SAMPLE_W-1:0] req_ref_sample_b = '0;
   logic signed [SAMPLE_W-1:0] req_ref_sample_c = '0;
   logic signed [SAMPLE_W-1:0] req_desired_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 0;
   logic signed [SAMPLE_W-1:0] rsp_error_sample;
   logic                       csr_write_enable = 0;
   logic        [MU_W-1:0]     csr_write_data = '0;

   nlms_error_scoreboard scoreboard;
   int  sender_idle_pct;     // chance per cycle of the sender holding off
   int  receiver_idle_pct;   // chance per cycle of the receiver stalling
   int  quiet_cycles;
   bit  stim_done;

   nlms_three_input_filter_core #(.TAPS(TAPS), .CHANNELS(CHANNELS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_ref_sample_a(req_ref_sample_a), .req_ref_sample_b(req_ref_sample_b),
      .req_ref_sample_c(req_ref_sample_c), .req_desired_sample(req_desired_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_error_sample(rsp_error_sample),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Monitor: requests and responses are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            scoreboard.note_request(req_ref_sample_a, req_ref_sample_b,
                                    req_ref_sample_c, req_desired_sample);
         if (rsp_valid && rsp_ready)
            scoreboard.check_response(rsp_error_sample);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: random stalls, changed at the falling edge.
   always @(negedge clock)
      rsp_ready <= !reset && ($urandom_range(99) >= receiver_idle_pct);

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Drive one request; valid holds until accepted and drops only while idling.
   task automatic send_request(logic signed [SAMPLE_W-1:0] sa,
                               logic signed [SAMPLE_W-1:0] sb,
                               logic signed [SAMPLE_W-1:0] sc,
                               logic signed [SAMPLE_W-1:0] desired);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid          <= 1;
      req_ref_sample_a   <= sa;
      req_ref_sample_b   <= sb;
      req_ref_sample_c   <= sc;
      req_desired_sample <= desired;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_random_request();
      logic [15:0] v[4];
      foreach (v[i]) begin
         case ($urandom_range(5))
            0: v[i] = 16'h7FFF;
            1: v[i] = 16'h8000;
            2: v[i] = 16'($urandom_range(63) - 32);
            default: v[i] = 16'($urandom);
         endcase
      end
      send_request(v[0], v[1], v[2], v[3]);
   endtask

   // Wait for every queued response, then for the block to settle.
   task automatic drain();
      req_valid <= 0;
      while (scoreboard.expected_errors.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_step_size(logic [MU_W-1:0] value);
      csr_write_enable <= 1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 0;
      scoreboard.mu = value;
   endtask

   initial begin
      scoreboard = new();
      scoreboard.clear_state();
      quiet_cycles = 0;
      sender_idle_pct = 14;
      receiver_idle_pct = 62;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: silent history, extremes, saturation of error and weights.
      send_request(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_request(16'sd0, 16'sd0, 16'sd0, 16'sh7FFF);
      send_request(16'sd0, 16'sd0, 16'sd0, 16'sh8000);
      send_request(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_request(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_request(16'sd1, -16'sd1, 16'sd0, 16'sh7FFF);
      send_request(-16'sd1, 16'sd1, 16'sh7FFF, 16'sh8000);
      drain();
      write_step_size(16'hFFFF);   // large mu drives weights to saturation
      for (int i = 0; i < 8; i++)
         send_request(16'sh7FFF, 16'sh8000, 16'sd1, (i & 1) ? 16'sh8000 : 16'sh7FFF);
      send_request(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_request(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      drain();
      write_step_size(16'h0000);
      send_request(16'sd100, -16'sd100, 16'sd7, 16'sh7FFF);
      send_request(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      drain();

      // Random phases over several step sizes and idle profiles.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin sender_idle_pct = 14; receiver_idle_pct = 62; end
            1: begin sender_idle_pct = 62; receiver_idle_pct = 14; end
            default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
         endcase
         case (phase)
            0: write_step_size(MU_RESET);
            1: write_step_size(16'h8000);
            2: write_step_size(16'h0001);
            3: write_step_size(16'hFFFF);
            4: write_step_size(16'($urandom));
            default: write_step_size(16'h0000);
         endcase
         for (int i = 0; i < RAND_REQS / 6; i++) send_random_request();
         drain();
      end

      repeat (REQ_CYCLES / 8 + 20) @(negedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.expected_errors.size() == 0)
         $display("*** PASSED ***");
      else begin
         if (scoreboard.expected_errors.size() != 0)
            scoreboard.report_mismatch("responses missing at end");
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

>>> filelist.f
rtl/nlms_pkg.sv
rtl/nlms_div.sv
rtl/nlms_ctrl.sv
rtl/nlms_dp.sv
rtl/nlms_three_input_filter_core.sv
verif/tb_nlms_three_input_filter_core.sv
